@@ sv/tmrl_pkg.sv @@
// shared types and constants of the trimmed mean range logger
package tmrl_pkg;

  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int TICKS_W = 24;
  localparam int STAMP_W = 48;
  localparam int DIST_W  = 24;
  localparam int SUM_W   = 32;
  localparam int TPC_W   = 16;
  localparam int SCNT_W  = 6;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam int DIV_W      = 32;
  localparam int DEN_W      = 16;
  localparam int STEP_W     = 6;
  localparam int DIST_STEPS = TICKS_W;
  localparam int MEAN_STEPS = DIV_W;

  localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST = SCNT_W'(5);
  localparam logic [TPC_W-1:0]  TICKS_PER_CM_RST = TPC_W'(23529);
  localparam logic              ENABLE_RST       = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_TICKS_PER_CM = 2'd1,
    REG_ENABLE       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_CHECK,
    ST_TRIM,
    ST_MEAN,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [TICKS_W-1:0] echo_ticks;
    logic [STAMP_W-1:0] stamp_us;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  mean_distance;
    logic [STAMP_W-1:0] entry_stamp;
    logic [3:0]         entry_slot;
    logic [4:0]         entries_held;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [STAMP_W-1:0] stamp;
  } ring_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/tmrl_div.sv @@
// shared radix-2 restoring divider, one quotient bit per cycle
module tmrl_div (
  input  logic               clk,
  input  logic               rst,
  input  tmrl_pkg::div_req_t req,
  output tmrl_pkg::div_rsp_t rsp
);
  import tmrl_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [DIV_W-1:0]  quo;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              fits;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= '0;
      quo   <= req.num;
      den_q <= req.den;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ sv/tmrl_ring.sv @@
// ring buffer storage for logged means and timestamps
module tmrl_ring (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [tmrl_pkg::SLOT_W-1:0]       wr_addr,
  input  tmrl_pkg::ring_entry_t             wr_data,
  input  logic                              rd_en,
  input  logic [tmrl_pkg::SLOT_W-1:0]       rd_addr,
  output tmrl_pkg::ring_entry_t             rd_data
);
  import tmrl_pkg::*;

  ring_entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/trimmed_mean_range_logger_unit.sv @@
// top level: burst tracking, sequencer and output register of the range logger
// a sample is taken in the accepting cycle, then the shared divider converts its ticks to centimetres
// and the quotient is taken; no new sample is accepted until this is done
// the last sample of a burst adds a divide for the mean, which is written to the ring, read back
// and loaded into the output register before the next beat (if disabled, no mean is computed)
// a stalled output holds the sequencer; synchronous reset restores the register defaults
// and clears the burst and ring count
module trimmed_mean_range_logger_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tmrl_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tmrl_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tmrl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tmrl_pkg::CFG_W-1:0]   cfg_data
);
  import tmrl_pkg::*;

  state_t state, state_next;

  logic [SCNT_W-1:0]  sample_count;
  logic [TPC_W-1:0]   ticks_per_cm;
  logic               enable;

  logic [SCNT_W-1:0]  samples_seen;
  logic [DIST_W-1:0]  min_distance;
  logic [DIST_W-1:0]  max_distance;
  logic [SUM_W-1:0]   distance_sum;
  logic [SLOT_W-1:0]  write_slot;
  logic [CNT_W-1:0]   valid_entries;

  logic [STAMP_W-1:0] stamp_q;
  logic [SCNT_W-1:0]  m_q;
  logic [SUM_W-1:0]   trim;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   held_q;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               ring_wr;
  logic               ring_rd;
  ring_entry_t        ring_wdata;
  ring_entry_t        ring_rdata;
  logic               out_load;
  logic               in_fire;

  logic [SCNT_W-1:0]  seen_inc;
  logic               burst_end;
  logic [DIST_W-1:0]  cur_distance;
  logic [DIST_W-1:0]  mean_sat;
  logic [CNT_W-1:0]   held_next;
  logic [SLOT_W-1:0]  slot_next;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  tmrl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tmrl_ring u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (write_slot),
    .wr_data (ring_wdata),
    .rd_en   (ring_rd),
    .rd_addr (slot_q),
    .rd_data (ring_rdata)
  );

  always_comb begin
    cur_distance = div_rsp.quo[DIST_W-1:0];
    seen_inc  = samples_seen + SCNT_W'(1);
    burst_end = (seen_inc == '0) ||
                ({1'b0, seen_inc} >= ({1'b0, m_q} + (SCNT_W + 1)'(2)));
    mean_sat  = (div_rsp.quo[DIV_W-1:DIST_W] != '0) ? '1 : div_rsp.quo[DIST_W-1:0];
    held_next = (valid_entries < CNT_W'(RING_DEPTH)) ? valid_entries + CNT_W'(1)
                                                       : valid_entries;
    slot_next = (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + SLOT_W'(1);
    ring_wdata.distance = mean_sat;
    ring_wdata.stamp    = stamp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.steps = '0;
    ring_wr       = 1'b0;
    ring_rd       = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(in_data.echo_ticks) << (DIV_W - TICKS_W);
          div_req.den   = (ticks_per_cm != '0) ? ticks_per_cm : TPC_W'(1);
          div_req.steps = STEP_W'(DIST_STEPS);
          state_next    = ST_DIST;
        end
      end
      ST_DIST: begin
        if (div_rsp.done) begin
          state_next = burst_end ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_next = ST_TRIM;
      end
      ST_TRIM: begin
        if (enable) begin
          div_req.start = 1'b1;
          div_req.num   = trim - SUM_W'(min_distance);
          div_req.den   = DEN_W'(m_q);
          div_req.steps = STEP_W'(MEAN_STEPS);
          state_next    = ST_MEAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          ring_wr    = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ring_rd    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_COUNT_RST;
      ticks_per_cm <= TICKS_PER_CM_RST;
      enable       <= ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_COUNT: sample_count <= cfg_data[SCNT_W-1:0];
        REG_TICKS_PER_CM: ticks_per_cm <= cfg_data[TPC_W-1:0];
        REG_ENABLE:       enable       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // burst accumulators and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen  <= '0;
      min_distance  <= '1;
      max_distance  <= '0;
      distance_sum  <= '0;
      write_slot    <= '0;
      valid_entries <= '0;
    end else begin
      if (state == ST_DIST && div_rsp.done) begin
        samples_seen <= seen_inc;
        distance_sum <= distance_sum + SUM_W'(cur_distance);
        if (cur_distance > max_distance) begin
          max_distance <= cur_distance;
        end
        if (cur_distance < min_distance) begin
          min_distance <= cur_distance;
        end
      end
      if (state == ST_TRIM) begin
        samples_seen <= '0;
        min_distance <= '1;
        max_distance <= '0;
        distance_sum <= '0;
      end
      if (ring_wr) begin
        write_slot    <= slot_next;
        valid_entries <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stamp_q <= in_data.stamp_us;
      m_q     <= (sample_count != '0) ? sample_count : SCNT_W'(1);
    end
    if (state == ST_CHECK) begin
      trim <= distance_sum - SUM_W'(max_distance);
    end
    if (ring_wr) begin
      slot_q <= write_slot;
      held_q <= held_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.mean_distance <= ring_rdata.distance;
      out_data.entry_stamp   <= ring_rdata.stamp;
      out_data.entry_slot    <= 4'(slot_q);
      out_data.entries_held  <= 5'(held_q);
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIST || state == ST_MEAN))
    else $error("divider finished outside a wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_entries <= CNT_W'(RING_DEPTH))
    else $error("ring count above depth");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken while an item is in work");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result shown without passing the output state");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (samples_seen != '0) |-> (min_distance <= max_distance))
    else $error("burst minimum above maximum");

endmodule
